/* rtl/syllable_swap_stego_embed_macros.svh */
// ----------------------------------------------------------------------------
// Syllable swap embedder assertion macros
// Clocked assertion wrappers used by the embedder RTL.
// ----------------------------------------------------------------------------
`ifndef SYLLABLE_SWAP_STEGO_EMBED_MACROS_SVH
`define SYLLABLE_SWAP_STEGO_EMBED_MACROS_SVH

// Property checked at every rising edge outside reset.
`define SSE_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SSE_ASSERT_NEVER(lbl, clk_s, rstn_s, cond, msg) \
  `SSE_ASSERT(lbl, clk_s, rstn_s, !(cond), msg)

`endif

/* rtl/sse_pkg.sv */
// ----------------------------------------------------------------------------
// Syllable swap embedder package
// Sizes, syllable pattern tables and shared types.
// ----------------------------------------------------------------------------
package sse_pkg;

  localparam int MAX_MESSAGE_BITS = 1024;
  localparam int WINDOW_BYTES     = 8;
  localparam int NUM_PAIRS        = 4;

  localparam int CNT_W     = $clog2(MAX_MESSAGE_BITS + 1);
  localparam int ADDR_W    = $clog2(MAX_MESSAGE_BITS);
  localparam int FILL_W    = $clog2(WINDOW_BYTES + 1);
  localparam int WIN_IDX_W = $clog2(WINDOW_BYTES);
  localparam int LOCK_W    = $clog2(WINDOW_BYTES);
  localparam int PAIR_W    = $clog2(NUM_PAIRS);
  localparam int IDX_W     = 11;

  localparam int OUT_DEPTH = 2;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  typedef logic [0:WINDOW_BYTES-1][7:0] win_t;

  // Syllable lengths in bytes; both members of a pair share the length.
  localparam logic [FILL_W-1:0] SYL_LEN [NUM_PAIRS] = '{
    FILL_W'(6), FILL_W'(6), FILL_W'(8), FILL_W'(6)
  };

  // Variant 0 / variant 1 of each pair, UTF-8, padded with zero.
  localparam win_t SYL_PAT [NUM_PAIRS][2] = '{
    '{ '{8'hD0, 8'hBA, 8'hD0, 8'hBE, 8'hD1, 8'h81, 8'h00, 8'h00},
       '{8'hD0, 8'hBA, 8'hD0, 8'hB0, 8'hD1, 8'h81, 8'h00, 8'h00} },
    '{ '{8'hD0, 8'hB3, 8'hD0, 8'hBE, 8'hD1, 8'h80, 8'h00, 8'h00},
       '{8'hD0, 8'hB3, 8'hD0, 8'hB0, 8'hD1, 8'h80, 8'h00, 8'h00} },
    '{ '{8'hD1, 8'h81, 8'hD1, 8'h82, 8'hD0, 8'hB5, 8'hD0, 8'hBB},
       '{8'hD1, 8'h81, 8'hD1, 8'h82, 8'hD0, 8'hB8, 8'hD0, 8'hBB} },
    '{ '{8'hD0, 8'hB1, 8'hD0, 8'hB5, 8'hD1, 8'h80, 8'h00, 8'h00},
       '{8'hD0, 8'hB1, 8'hD0, 8'hB8, 8'hD1, 8'h80, 8'h00, 8'h00} }
  };

  // Outcome of deciding the window head.
  typedef struct packed {
    win_t              win;
    logic [7:0]        out_byte;
    logic              consume;
    logic [LOCK_W-1:0] lock;
    logic [FILL_W-1:0] fill;
  } dec_t;

  typedef struct packed {
    logic [7:0]              out_byte;
    logic                    is_last;
    logic signed [IDX_W-1:0] last_bit_index;
  } out_t;

endpackage

/* rtl/sse_if.sv */
// ----------------------------------------------------------------------------
// Syllable swap embedder channels
// Valid/ready interfaces for the input and result streams.
// ----------------------------------------------------------------------------
interface sse_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic       message_bit;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, mode, message_bit, text_byte, end_of_text,
                  input ready);
  modport sink   (input valid, mode, message_bit, text_byte, end_of_text,
                  output ready);
endinterface

interface sse_out_if;
  logic                    valid;
  logic                    ready;
  logic [7:0]              out_byte;
  logic                    is_last;
  logic signed [10:0]      last_bit_index;

  modport source (output valid, out_byte, is_last, last_bit_index, input ready);
  modport sink   (input valid, out_byte, is_last, last_bit_index, output ready);
endinterface

/* rtl/syllable_swap_stego_embed.sv */
// ----------------------------------------------------------------------------
// Syllable swap stego embedder
// Hides stored message bits in UTF-8 text by swapping syllable variants.
//
//   channel  | dir | payload                                   | transfer
//   in_ch    | in  | mode, message_bit, text_byte, end_of_text | valid & ready
//   out_ch   | out | out_byte, is_last, last_bit_index         | valid & ready
//
// One input item per cycle unless draining or the result buffer is full; a
// text byte leaves seven bytes later. An end-of-text byte drains the window,
// one result per cycle when the buffer has room; no input is taken meanwhile.
// The bit store is a single-port-write memory with a registered read at the
// next read pointer; a bit loaded in the cycle before its use is bypassed.
// A two-entry result buffer keeps input moving while a result waits.
// Reset (rst_n low, synchronous) empties window, counters and result buffer.
// ----------------------------------------------------------------------------
`include "syllable_swap_stego_embed_macros.svh"

module syllable_swap_stego_embed (
  input logic        clk,
  input logic        rst_n,
  sse_in_if.sink     in_ch,
  sse_out_if.source  out_ch
);

  // window and bit pointers
  sse_pkg::win_t               win_r,     win_nxt;
  logic [sse_pkg::FILL_W-1:0]  fill_r,    fill_nxt;
  logic [sse_pkg::LOCK_W-1:0]  lock_r,    lock_nxt;
  logic [sse_pkg::CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [sse_pkg::CNT_W-1:0]   rp_r,      rp_nxt;
  logic                        flush_r,   flush_nxt;

  // result buffer
  sse_pkg::out_t                 slot_r [sse_pkg::OUT_DEPTH];
  logic [sse_pkg::OUT_PTR_W-1:0] wr_ptr_r;
  logic [sse_pkg::OUT_PTR_W-1:0] rd_ptr_r;
  logic [sse_pkg::OUT_CNT_W-1:0] out_cnt_r;

  logic                        accept;
  logic                        ld;
  logic                        txt;
  logic                        store_we;
  logic                        store_bit;
  sse_pkg::win_t               win_in;
  logic [sse_pkg::FILL_W-1:0]  fill_in;
  sse_pkg::win_t               dec_win;
  logic [sse_pkg::FILL_W-1:0]  dec_fill;
  sse_pkg::dec_t               dec;
  logic                        do_emit;
  logic                        last;
  logic [sse_pkg::CNT_W-1:0]   rp_after;
  logic [sse_pkg::CNT_W-1:0]   rp_m1;
  logic signed [sse_pkg::IDX_W-1:0] last_idx;
  sse_pkg::out_t               entry;
  logic                        pop;
  logic                        buf_full;

  assign buf_full    = (out_cnt_r == sse_pkg::OUT_CNT_W'(sse_pkg::OUT_DEPTH));
  assign in_ch.ready = !flush_r && !buf_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign ld          = accept && !in_ch.mode;
  assign txt         = accept && in_ch.mode;
  assign store_we    = ld && (bit_cnt_r < sse_pkg::CNT_W'(sse_pkg::MAX_MESSAGE_BITS));

  // place the incoming byte behind the filled part of the window
  always_comb begin
    win_in = win_r;
    if (txt) begin
      win_in[fill_r[sse_pkg::WIN_IDX_W-1:0]] = in_ch.text_byte;
    end
  end
  assign fill_in = fill_r + sse_pkg::FILL_W'(txt);

  assign dec_win  = flush_r ? win_r  : win_in;
  assign dec_fill = flush_r ? fill_r : fill_in;

  sse_decide u_decide (
    .win_i   (dec_win),
    .fill_i  (dec_fill),
    .lock_i  (lock_r),
    .avail_i (rp_r < bit_cnt_r),
    .bit_i   (store_bit),
    .dec_o   (dec)
  );

  assign do_emit = flush_r ? !buf_full
                           : (txt && (in_ch.end_of_text ||
                              (fill_in == sse_pkg::FILL_W'(sse_pkg::WINDOW_BYTES))));
  assign last     = do_emit && (dec.fill == '0);
  assign rp_after = rp_r + sse_pkg::CNT_W'(dec.consume);
  assign rp_m1    = rp_after - 1'b1;
  assign last_idx = (rp_after == '0) ? '1 : sse_pkg::IDX_W'(rp_m1);

  always_comb begin
    win_nxt     = win_r;
    fill_nxt    = fill_r;
    lock_nxt    = lock_r;
    rp_nxt      = rp_r;
    bit_cnt_nxt = bit_cnt_r;
    flush_nxt   = flush_r;
    if (store_we) begin
      bit_cnt_nxt = bit_cnt_r + 1'b1;
    end
    if (do_emit) begin
      win_nxt   = dec.win;
      fill_nxt  = dec.fill;
      lock_nxt  = dec.lock;
      rp_nxt    = rp_after;
      flush_nxt = flush_r || (txt && in_ch.end_of_text);
    end else if (txt) begin
      win_nxt  = win_in;
      fill_nxt = fill_in;
    end
    // end of text: drop all message state
    if (last) begin
      fill_nxt    = '0;
      lock_nxt    = '0;
      rp_nxt      = '0;
      bit_cnt_nxt = '0;
      flush_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      lock_r    <= '0;
      rp_r      <= '0;
      bit_cnt_r <= '0;
      flush_r   <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      lock_r    <= lock_nxt;
      rp_r      <= rp_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      flush_r   <= flush_nxt;
    end
  end

  // read at the next read pointer so the bit at the read pointer is ready when needed
  sse_bitmem u_bitmem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (store_we),
    .waddr (bit_cnt_r[sse_pkg::ADDR_W-1:0]),
    .wdata (in_ch.message_bit),
    .raddr (rp_nxt[sse_pkg::ADDR_W-1:0]),
    .rdata (store_bit)
  );

  // result buffer
  always_comb begin
    entry.out_byte       = dec.out_byte;
    entry.is_last        = last;
    entry.last_bit_index = last ? last_idx : '0;
  end

  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (do_emit) begin
      slot_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      out_cnt_r <= '0;
    end else begin
      if (do_emit) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      out_cnt_r <= out_cnt_r + sse_pkg::OUT_CNT_W'(do_emit)
                             - sse_pkg::OUT_CNT_W'(pop);
    end
  end

  assign out_ch.valid          = (out_cnt_r != '0);
  assign out_ch.out_byte       = slot_r[rd_ptr_r].out_byte;
  assign out_ch.is_last        = slot_r[rd_ptr_r].is_last;
  assign out_ch.last_bit_index = slot_r[rd_ptr_r].last_bit_index;

  `SSE_ASSERT(a_fill_range, clk, rst_n, fill_r < sse_pkg::FILL_W'(sse_pkg::WINDOW_BYTES), "window fill out of range")
  `SSE_ASSERT(a_rp_le_cnt, clk, rst_n, rp_r <= bit_cnt_r, "read pointer passed bit count")
  `SSE_ASSERT(a_lock_has_bit, clk, rst_n, (lock_r != '0) |-> (rp_r != '0), "lock without consumed bit")
  `SSE_ASSERT(a_last_clears, clk, rst_n, last |=> (fill_r == '0 && bit_cnt_r == '0 && !flush_r), "end of text did not clear state")
  `SSE_ASSERT_NEVER(a_buf_over, clk, rst_n, out_cnt_r > sse_pkg::OUT_CNT_W'(sse_pkg::OUT_DEPTH), "result buffer overflow")

endmodule

/* rtl/sse_bitmem.sv */
// ----------------------------------------------------------------------------
// Message bit store
// Single-bit synchronous memory, one write and one registered read per cycle,
// with write-to-read bypass on a same-address collision.
// ----------------------------------------------------------------------------
module sse_bitmem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      we,
  input  logic [sse_pkg::ADDR_W-1:0] waddr,
  input  logic                      wdata,
  input  logic [sse_pkg::ADDR_W-1:0] raddr,
  output logic                      rdata
);

  logic mem [sse_pkg::MAX_MESSAGE_BITS];
  logic rd_r;
  logic fwd_r;
  logic fwd_bit_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r      <= mem[raddr];
    fwd_bit_r <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= we && (waddr == raddr);
    end
  end

  // take the bit being written when the read hit the same entry
  assign rdata = fwd_r ? fwd_bit_r : rd_r;

endmodule

/* rtl/sse_decide.sv */
// ----------------------------------------------------------------------------
// Window head decision
// Matches the syllable pairs at the window head, substitutes the selected
// variant, emits the head byte and shifts the window by one.
// ----------------------------------------------------------------------------
module sse_decide (
  input  sse_pkg::win_t                win_i,
  input  logic [sse_pkg::FILL_W-1:0]   fill_i,
  input  logic [sse_pkg::LOCK_W-1:0]   lock_i,
  input  logic                         avail_i,
  input  logic                         bit_i,
  output sse_pkg::dec_t                dec_o
);

  logic [sse_pkg::NUM_PAIRS-1:0] eq0;
  logic [sse_pkg::NUM_PAIRS-1:0] eq1;
  logic [sse_pkg::NUM_PAIRS-1:0] hit;
  logic [sse_pkg::PAIR_W-1:0]    sel;
  logic                          take;
  sse_pkg::win_t                 wmod;

  always_comb begin
    for (int p = 0; p < sse_pkg::NUM_PAIRS; p++) begin
      eq0[p] = 1'b1;
      eq1[p] = 1'b1;
      for (int i = 0; i < sse_pkg::WINDOW_BYTES; i++) begin
        if (i < int'(sse_pkg::SYL_LEN[p])) begin
          eq0[p] = eq0[p] && (win_i[i] == sse_pkg::SYL_PAT[p][0][i]);
          eq1[p] = eq1[p] && (win_i[i] == sse_pkg::SYL_PAT[p][1][i]);
        end
      end
      // only a syllable held whole in the window counts
      hit[p] = (fill_i >= sse_pkg::SYL_LEN[p]) && (eq0[p] || eq1[p]);
    end
  end

  // pairs differ in their first letter, so at most one hits
  always_comb begin
    sel = '0;
    for (int p = 0; p < sse_pkg::NUM_PAIRS; p++) begin
      if (hit[p]) begin
        sel = sse_pkg::PAIR_W'(p);
      end
    end
  end

  assign take = (lock_i == '0) && avail_i && (|hit);

  always_comb begin
    wmod = win_i;
    if (take) begin
      for (int i = 0; i < sse_pkg::WINDOW_BYTES; i++) begin
        if (i < int'(sse_pkg::SYL_LEN[sel])) begin
          wmod[i] = sse_pkg::SYL_PAT[sel][bit_i][i];
        end
      end
    end
  end

  always_comb begin
    dec_o.out_byte = wmod[0];
    for (int i = 0; i < sse_pkg::WINDOW_BYTES - 1; i++) begin
      dec_o.win[i] = wmod[i+1];
    end
    dec_o.win[sse_pkg::WINDOW_BYTES-1] = 8'h00;
    dec_o.consume = take;
    dec_o.fill    = fill_i - 1'b1;
    if (lock_i != '0) begin
      dec_o.lock = lock_i - 1'b1;
    end else if (take) begin
      // hold the rest of the syllable unchanged
      dec_o.lock = sse_pkg::LOCK_W'(sse_pkg::SYL_LEN[sel] - 1'b1);
    end else begin
      dec_o.lock = '0;
    end
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// Syllable swap embedder testbench
// Loads message bits and streams cover text through the embedder. A local
// model of the lookahead window and bit store predicts every stego byte, and
// each result transfer is compared field by field against that prediction.
// A short table of hand-picked items comes first, then random messages and
// texts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT     = 22;
  localparam int RANDOM_ITEMS = 280;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 24;
  localparam int TABLE_ROWS   = 25;

  typedef enum logic {
    OP_LOAD_BIT  = 1'b0,
    OP_TEXT_BYTE = 1'b1
  } op_t;

  // Syllable pairs, first byte in the top bits, zero padded.
  localparam int          PAIR_BYTES [sse_pkg::NUM_PAIRS] = '{6, 6, 8, 6};
  localparam logic [63:0] PAIR_WORD [sse_pkg::NUM_PAIRS][2] = '{
    '{64'hD0BA_D0BE_D181_0000, 64'hD0BA_D0B0_D181_0000},
    '{64'hD0B3_D0BE_D180_0000, 64'hD0B3_D0B0_D180_0000},
    '{64'hD181_D182_D0B5_D0BB, 64'hD181_D182_D0B8_D0BB},
    '{64'hD0B1_D0B5_D180_0000, 64'hD0B1_D0B8_D180_0000}
  };

  localparam sse_pkg::out_t NO_WANT = '0;

  typedef struct {
    op_t           op;
    logic          mbit;
    logic [7:0]    tbyte;
    logic          eot;
    bit            typed;
    sse_pkg::out_t want;
  } stim_row_t;

  typedef struct {
    bit            typed;
    sse_pkg::out_t want;
  } typed_note_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  sse_in_if  in_ch ();
  sse_out_if out_ch ();

  syllable_swap_stego_embed dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Embedder model state
  logic [7:0]  win_q [sse_pkg::WINDOW_BYTES];
  int unsigned win_fill;
  int unsigned lock_left;
  int unsigned rd_ptr;
  int unsigned msg_count;
  logic        msg_store [sse_pkg::MAX_MESSAGE_BITS];

  sse_pkg::out_t stego_q [$];
  typed_note_t   note_q [$];
  logic [7:0]    cover_text [$];
  stim_row_t     table_rows [TABLE_ROWS];

  int          idle_pct = IDLE_PCT;
  int unsigned cycle_count;
  int unsigned sent_items;
  int unsigned texts_sent;
  int unsigned checked_count;
  int unsigned swap_count;
  int unsigned fail_count;

  function automatic bit pair_hit(int p, int v);
    for (int i = 0; i < PAIR_BYTES[p]; i++) begin
      if (win_q[i] != PAIR_WORD[p][v][63-8*i -: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Decide the head byte, queue it as expected, shift the window.
  function automatic void release_head();
    sse_pkg::out_t r;
    logic          b;
    bit            done;
    done = 1'b0;
    if (lock_left > 0) begin
      lock_left--;
    end else if (rd_ptr < msg_count) begin
      for (int p = 0; p < sse_pkg::NUM_PAIRS; p++) begin
        if (!done && PAIR_BYTES[p] <= win_fill && (pair_hit(p, 0) || pair_hit(p, 1))) begin
          b = msg_store[rd_ptr];
          for (int i = 0; i < PAIR_BYTES[p]; i++) begin
            win_q[i] = PAIR_WORD[p][b][63-8*i -: 8];
          end
          rd_ptr++;
          lock_left = PAIR_BYTES[p] - 1;
          swap_count++;
          done = 1'b1;
        end
      end
    end
    r = '0;
    r.out_byte = win_q[0];
    stego_q.insert(stego_q.size(), r);
    for (int i = 0; i < sse_pkg::WINDOW_BYTES - 1; i++) begin
      win_q[i] = win_q[i+1];
    end
    win_q[sse_pkg::WINDOW_BYTES-1] = '0;
    if (win_fill > 0) win_fill--;
  endfunction

  function automatic void clear_text_state();
    msg_count = 0;
    rd_ptr    = 0;
    win_fill  = 0;
    lock_left = 0;
    for (int i = 0; i < sse_pkg::WINDOW_BYTES; i++) begin
      win_q[i] = '0;
    end
  endfunction

  function automatic void predict_stego(logic mode, logic mbit, logic [7:0] tbyte, logic eot);
    sse_pkg::out_t r;
    if (mode == OP_LOAD_BIT) begin
      // drop bits past capacity
      if (msg_count < sse_pkg::MAX_MESSAGE_BITS) begin
        msg_store[msg_count] = mbit;
        msg_count++;
      end
      return;
    end
    if (win_fill >= sse_pkg::WINDOW_BYTES) release_head();
    win_q[win_fill] = tbyte;
    win_fill++;
    if (!eot) begin
      if (win_fill == sse_pkg::WINDOW_BYTES) release_head();
      return;
    end
    while (win_fill > 0) release_head();
    r = stego_q.pop_back();
    r.is_last = 1'b1;
    if (rd_ptr == 0) begin
      r.last_bit_index = '1;
    end else begin
      r.last_bit_index = sse_pkg::IDX_W'(rd_ptr - 1);
    end
    stego_q.insert(stego_q.size(), r);
    clear_text_state();
  endfunction

  // Hold valid until the transfer; idle at random before raising it.
  task automatic send(input op_t op, input logic mbit, input logic [7:0] tbyte,
                      input logic eot, input bit typed, input sse_pkg::out_t want);
    typed_note_t note;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= op;
    in_ch.message_bit <= mbit;
    in_ch.text_byte   <= tbyte;
    in_ch.end_of_text <= eot;
    note.typed = typed;
    note.want  = want;
    note_q.insert(note_q.size(), note);
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  // Load a message, then stream one cover text built mostly from syllables.
  task automatic send_text(input int nbits, input int target, input int syl_pct,
                           input int mid_pct);
    int pick;
    int p;
    int v;
    int n;
    int flaw;
    cover_text.delete();
    while (cover_text.size() < target) begin
      pick = $urandom_range(99);
      p    = $urandom_range(sse_pkg::NUM_PAIRS - 1);
      v    = $urandom_range(1);
      if (pick < syl_pct) begin
        n    = PAIR_BYTES[p];
        flaw = -1;
        // break some syllables: cut short or one byte off
        if (syl_pct < 100 && $urandom_range(4) == 0) begin
          if ($urandom_range(1)) n = $urandom_range(n - 1, 1);
          else flaw = $urandom_range(n - 1);
        end
        for (int i = 0; i < n; i++) begin
          cover_text.insert(cover_text.size(),
                            i == flaw ? 8'($urandom_range(255))
                                      : PAIR_WORD[p][v][63-8*i -: 8]);
        end
      end else if (pick < syl_pct + 12) begin
        cover_text.insert(cover_text.size(),
                          $urandom_range(4) == 0 ? 8'h20 : 8'($urandom_range(122, 97)));
      end else if (pick < syl_pct + 22) begin
        cover_text.insert(cover_text.size(), 8'($urandom_range(8'hD1, 8'hD0)));
        cover_text.insert(cover_text.size(), 8'($urandom_range(8'hBF, 8'h80)));
      end else begin
        cover_text.insert(cover_text.size(), 8'($urandom_range(255)));
      end
    end
    for (int i = 0; i < nbits; i++) begin
      send(OP_LOAD_BIT, 1'($urandom_range(1)), 8'($urandom_range(255)),
           1'($urandom_range(1)), 1'b0, NO_WANT);
    end
    for (int i = 0; i < cover_text.size(); i++) begin
      if ($urandom_range(99) < mid_pct) begin
        send(OP_LOAD_BIT, 1'($urandom_range(1)), 8'($urandom_range(255)),
             1'($urandom_range(1)), 1'b0, NO_WANT);
      end
      send(OP_TEXT_BYTE, 1'($urandom_range(1)), cover_text[i],
           i == cover_text.size() - 1, 1'b0, NO_WANT);
    end
    texts_sent++;
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    typed_note_t   note;
    sse_pkg::out_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        note = note_q.pop_front();
        predict_stego(in_ch.mode, in_ch.message_bit, in_ch.text_byte, in_ch.end_of_text);
        if (note.typed) begin
          void'(stego_q.pop_back());
          stego_q.insert(stego_q.size(), note.want);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (stego_q.size() == 0) begin
          $error("unexpected stego byte %02h", out_ch.out_byte);
          fail_count++;
        end else begin
          want = stego_q.pop_front();
          checked_count++;
          if (out_ch.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.is_last !== want.is_last) begin
            $error("is_last: expected %0d, got %0d", want.is_last, out_ch.is_last);
            fail_count++;
          end
          if (out_ch.last_bit_index !== want.last_bit_index) begin
            $error("last_bit_index: expected %0d, got %0d",
                   want.last_bit_index, out_ch.last_bit_index);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results pending", cycle_count, stego_q.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned first_random;
    int unsigned text_no;
    in_ch.valid       = 1'b0;
    in_ch.mode        = OP_LOAD_BIT;
    in_ch.message_bit = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    clear_text_state();

    // Lone bytes with no message, an ignored end flag on a bit load, then
    // one full syllable of three pairs, each ending its text.
    table_rows = '{
      '{OP_TEXT_BYTE, 1'b0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, -11'sd1}},
      '{OP_TEXT_BYTE, 1'b1, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, -11'sd1}},
      '{OP_LOAD_BIT,  1'b1, 8'hFF, 1'b1, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'hD0, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'hBA, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'hD0, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'hBE, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'hD1, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'h81, 1'b1, 1'b0, NO_WANT},
      '{OP_LOAD_BIT,  1'b0, 8'h00, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b1, 8'hD1, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b1, 8'h81, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b1, 8'hD1, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b1, 8'h82, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b1, 8'hD0, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b1, 8'hB8, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b1, 8'hD0, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b1, 8'hBB, 1'b1, 1'b0, NO_WANT},
      '{OP_LOAD_BIT,  1'b1, 8'h00, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'hD0, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'hB3, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'hD0, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'hBE, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'hD1, 1'b0, 1'b0, NO_WANT},
      '{OP_TEXT_BYTE, 1'b0, 8'h80, 1'b1, 1'b0, NO_WANT}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) begin
      send(table_rows[i].op, table_rows[i].mbit, table_rows[i].tbyte,
           table_rows[i].eot, table_rows[i].typed, table_rows[i].want);
      if (table_rows[i].op == OP_TEXT_BYTE && table_rows[i].eot) texts_sent++;
    end

    first_random = sent_items;
    text_no      = 0;
    while (sent_items - first_random < RANDOM_ITEMS) begin
      // run a few texts back to back with no idling on either side
      idle_pct = (text_no >= 4 && text_no < 9) ? 0 : IDLE_PCT;
      send_text($urandom_range(10, 0), $urandom_range(40, 1), 70, 8);
      text_no++;
    end
    idle_pct = IDLE_PCT;
    in_ch.valid <= 1'b0;

    while (stego_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d input transfers over %0d texts in %0d cycles", sent_items, texts_sent,
             cycle_count);
    $display("%0d stego bytes checked, %0d syllables swapped", checked_count, swap_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
